// File: sv/sm3_pkg.sv
// Shared types, constants and round helper functions for the SM3 hash engine.
package sm3_pkg;

	typedef struct packed {
		logic [31:0] msg_word;
		logic [2:0]  valid_bytes;
		logic        last_item;
	} sm3_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} sm3_out_t;

	typedef logic [31:0] sm3_word_t;

	localparam sm3_word_t SM3_IV [8] = '{
		32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
		32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
	};

	localparam sm3_word_t SM3_T_LO = 32'h79cc4519;
	localparam sm3_word_t SM3_T_HI = 32'h7a879d8a;
	localparam sm3_word_t SM3_PAD_ONE = 32'h80000000;

	function automatic sm3_word_t rotl(input sm3_word_t x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic sm3_word_t perm0(input sm3_word_t x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic sm3_word_t perm1(input sm3_word_t x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

	// Round constant already rotated by the round number modulo 32.
	function automatic sm3_word_t round_const(input logic [5:0] j);
		sm3_word_t t;
		t = (j[5:4] == 2'd0) ? SM3_T_LO : SM3_T_HI;
		return rotl(t, j[4:0]);
	endfunction

endpackage

// File: sv/sm3_hash_engine_unit.sv
// SM3 hash engine: message intake, padding, iterative compression and digest output.
//
// Usage:
//   Message words enter on msg_valid/msg_ready/msg_data, big-endian, four bytes
//   each; the item marked last_item may carry 0 to 4 bytes (valid_bytes, values
//   above four count as four). Digest words leave on dgst_valid/dgst_ready/
//   dgst_data, eight transfers per message, word_index 0 first, last_word on
//   the eighth.
// Timing:
//   Every sixteenth word starts a compression, one SM3 round per cycle through
//   a single round unit with the message expansion computed on the fly in a
//   16-word window; no new word is taken until the compression ends.
//   A last item places one padding word per cycle (up to 16), runs one or two
//   compressions, then offers the digest on dgst_valid/dgst_data.
// Reset and stalls:
//   arst_n loads the standard initial value and clears the length and the word
//   count. msg_ready is low while a block compresses, while padding runs and
//   while digest words are pending; a stalled receiver simply holds the digest
//   state, and after the eighth transfer the engine starts a fresh message.
module sm3_hash_engine_unit
	import sm3_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     msg_valid,
	output logic     msg_ready,
	input  sm3_in_t  msg_data,
	output logic     dgst_valid,
	input  logic     dgst_ready,
	output sm3_out_t dgst_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PAD  = 2'd1;
	localparam logic [1:0] ST_COMP = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]  state_q, ret_q;
	logic [3:0]  wib_q;
	logic [63:0] bits_q;
	logic [5:0]  round_q;
	logic [2:0]  out_idx_q;
	logic        one_pending_q, hi_done_q;
	sm3_word_t   chain_q [8];
	sm3_word_t   v_q [8];
	sm3_word_t   win_q [16];

	// Intake decode
	logic      msg_xfer, dgst_xfer;
	logic [2:0] nb_sat;
	sm3_word_t last_word_d, pad_word_d;

	assign msg_ready = (state_q == ST_IDLE);
	assign msg_xfer  = msg_valid && msg_ready;
	assign dgst_valid = (state_q == ST_OUT);
	assign dgst_xfer = dgst_valid && dgst_ready;

	assign nb_sat = (msg_data.valid_bytes > 3'd4) ? 3'd4 : msg_data.valid_bytes;

	// Mask unused low bytes and append the 1 bit directly after the data; a full word leaves it pending for padding.
	always_comb begin
		case (nb_sat)
			3'd0: last_word_d = 32'h80000000;
			3'd1: last_word_d = {msg_data.msg_word[31:24], 24'h800000};
			3'd2: last_word_d = {msg_data.msg_word[31:16], 16'h8000};
			3'd3: last_word_d = {msg_data.msg_word[31:8], 8'h80};
			default: last_word_d = msg_data.msg_word;
		endcase
	end

	// Padding sequence: pending 1 bit, zero fill, then length high and low.
	always_comb begin
		if (one_pending_q) begin
			pad_word_d = SM3_PAD_ONE;
		end else if (wib_q == 4'd14) begin
			pad_word_d = bits_q[63:32];
		end else if (wib_q == 4'd15 && hi_done_q) begin
			pad_word_d = bits_q[31:0];
		end else begin
			pad_word_d = '0;
		end
	end

	// Shared round unit
	sm3_word_t a12, ss1, ss2, ff, gg, tt1, tt2, w_next;
	always_comb begin
		a12 = rotl(v_q[0], 5'd12);
		ss1 = rotl(a12 + v_q[4] + round_const(round_q), 5'd7);
		ss2 = ss1 ^ a12;
		if (round_q[5:4] == 2'd0) begin
			ff = v_q[0] ^ v_q[1] ^ v_q[2];
			gg = v_q[4] ^ v_q[5] ^ v_q[6];
		end else begin
			ff = (v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]);
			gg = (v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]);
		end
		tt1 = ff + v_q[3] + ss2 + (win_q[0] ^ win_q[4]);
		tt2 = gg + v_q[7] + ss1 + win_q[0];
		w_next = perm1(win_q[0] ^ win_q[7] ^ rotl(win_q[13], 5'd15))
			^ rotl(win_q[3], 5'd7) ^ win_q[10];
	end

	// Sequencer, counters and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ret_q         <= ST_IDLE;
			wib_q         <= '0;
			bits_q        <= '0;
			round_q       <= '0;
			out_idx_q     <= '0;
			one_pending_q <= 1'b0;
			hi_done_q     <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= SM3_IV[i];
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (msg_xfer) begin
						wib_q <= wib_q + 4'd1;
						if (msg_data.last_item) begin
							bits_q <= bits_q + {58'd0, nb_sat, 3'b000};
							one_pending_q <= (nb_sat == 3'd4);
						end else begin
							bits_q <= bits_q + 64'd32;
						end
						if (wib_q == 4'd15) begin
							state_q <= ST_COMP;
							ret_q   <= msg_data.last_item ? ST_PAD : ST_IDLE;
						end else if (msg_data.last_item) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					wib_q <= wib_q + 4'd1;
					one_pending_q <= 1'b0;
					if (!one_pending_q && wib_q == 4'd14) begin
						hi_done_q <= 1'b1;
					end
					if (wib_q == 4'd15) begin
						state_q <= ST_COMP;
						if (!one_pending_q && hi_done_q) begin
							ret_q     <= ST_OUT;
							hi_done_q <= 1'b0;
						end else begin
							ret_q <= ST_PAD;
						end
					end
				end
				ST_COMP: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						state_q <= ret_q;
						chain_q[0] <= chain_q[0] ^ tt1;
						chain_q[1] <= chain_q[1] ^ v_q[0];
						chain_q[2] <= chain_q[2] ^ rotl(v_q[1], 5'd9);
						chain_q[3] <= chain_q[3] ^ v_q[2];
						chain_q[4] <= chain_q[4] ^ perm0(tt2);
						chain_q[5] <= chain_q[5] ^ v_q[4];
						chain_q[6] <= chain_q[6] ^ rotl(v_q[5], 5'd19);
						chain_q[7] <= chain_q[7] ^ v_q[6];
					end
				end
				ST_OUT: begin
					if (dgst_xfer) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7) begin
							// Start the next message from the initial state.
							state_q <= ST_IDLE;
							bits_q  <= '0;
							wib_q   <= '0;
							for (int i = 0; i < 8; i++) begin
								chain_q[i] <= SM3_IV[i];
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Block window: filled by address, shifted during compression; working vars.
	always_ff @(posedge clk) begin
		if ((msg_xfer || state_q == ST_PAD) && wib_q == 4'd15) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= chain_q[i];
			end
		end
		case (state_q)
			ST_IDLE: begin
				if (msg_xfer) begin
					win_q[wib_q] <= msg_data.last_item ? last_word_d : msg_data.msg_word;
				end
			end
			ST_PAD: begin
				win_q[wib_q] <= pad_word_d;
			end
			ST_COMP: begin
				for (int i = 0; i < 15; i++) begin
					win_q[i] <= win_q[i + 1];
				end
				win_q[15] <= w_next;
				v_q[0] <= tt1;
				v_q[1] <= v_q[0];
				v_q[2] <= rotl(v_q[1], 5'd9);
				v_q[3] <= v_q[2];
				v_q[4] <= perm0(tt2);
				v_q[5] <= v_q[4];
				v_q[6] <= rotl(v_q[5], 5'd19);
				v_q[7] <= v_q[6];
			end
			default: begin
			end
		endcase
	end

	// Digest output
	assign dgst_data.digest_word = chain_q[out_idx_q];
	assign dgst_data.word_index  = out_idx_q;
	assign dgst_data.last_word   = (out_idx_q == 3'd7);

	// A compression always starts and runs with an empty fill count.
	a_comp_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP) |-> (wib_q == 4'd0))
		else $error("fill count nonzero during compression");

	// Compression is never cut short.
	a_comp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP && round_q != 6'd63) |=> (state_q == ST_COMP))
		else $error("compression left early");

	// No intake while digest words are offered.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		dgst_valid |-> !msg_ready)
		else $error("input accepted during digest output");

	// After the final digest transfer the engine is back at its initial state.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(dgst_xfer && dgst_data.last_word) |=>
		(state_q == ST_IDLE && wib_q == 4'd0 && bits_q == 64'd0 && out_idx_q == 3'd0))
		else $error("engine not reset after digest");

endmodule
